### src/emss_pkg.sv
// Package: shared types, constants and command/status structs for the ensemble stats store.
package emss_pkg;

  localparam int ENS_MAX_DEF = 64;
  localparam int OBS_MAX_DEF = 64;
  localparam int CFG_W       = 7;
  localparam int IDX_W       = 6;
  localparam int SAMPLE_W    = 32;
  localparam int STD_W       = 31;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_DEACT = 2'd1;
  localparam logic [1:0] OP_STATS = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic CFG_ENS = 1'b0;
  localparam logic CFG_OBS = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_CLR,
    ST_ACC,
    ST_DRAIN,
    ST_DIV,
    ST_SQ,
    ST_SQRT,
    ST_STORE,
    ST_OUT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic do_write;
    logic do_deact;
    logic rd_issue;
    logic clr_acc;
    logic acc_issue;
    logic div_start;
    logic sq_load;
    logic sqrt_start;
    logic store_stats;
    logic out_load;
    logic out_err;
    logic out_stats;
  } ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic last_member;
    logic last_obs;
    logic pipe_busy;
  } stat_t;

endpackage

### src/ensemble_mean_std_store.sv
// Top level: ensemble mean and standard deviation store.
// channel | direction | handshake            | fields
// in      | input     | in_valid / in_stall   | op, member_index, obs_addr, sample_value
// out     | output    | out_valid / out_stall | mean_value, std_value, obs_active, status
// cfg     | input     | cfg_we                | cfg_index, cfg_data
// Write, deactivate and error words load the output from idle; a read first passes the read state (stats memory port).
// Stats runs per observation through clear, accumulate (fetch, square), pipe drain, divide,
// mean square, root and store, then loads one output word; of these steps the serial divider
// takes the longest.
// Reset clears the flags, counts and control; results wait in one output register.
module ensemble_mean_std_store #(
  parameter int ENS_MAX = emss_pkg::ENS_MAX_DEF,
  parameter int OBS_MAX = emss_pkg::OBS_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [emss_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_op,
  input  logic [5:0]                 in_member_index,
  input  logic [5:0]                 in_obs_addr,
  input  logic signed [31:0]         in_sample_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [31:0]         out_mean_value,
  output logic [30:0]                out_std_value,
  output logic                       out_obs_active,
  output logic                       out_status
);

  emss_pkg::ctrl_t cmd;
  emss_pkg::stat_t st;
  logic idx_err, out_busy;

  emss_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .op(in_op), .idx_err, .out_busy, .st, .cmd
  );

  emss_dp #(.ENS_MAX(ENS_MAX), .OBS_MAX(OBS_MAX)) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .op(in_op), .member_index(in_member_index), .obs_addr(in_obs_addr),
    .sample_value(in_sample_value), .cmd, .st, .idx_err, .out_busy, .out_stall,
    .out_valid, .mean_value(out_mean_value), .std_value(out_std_value),
    .obs_active(out_obs_active), .status(out_status)
  );

  // A write and a deactivate never fire together
  assert property (@(posedge clk) disable iff (!rst_n) !(cmd.do_write && cmd.do_deact))
    else $error("write and deactivate together");
  // Output loads only when the register is free
  assert property (@(posedge clk) disable iff (!rst_n) cmd.out_load |-> !out_busy)
    else $error("output overwritten");
  // Out of range words report error status
  assert property (@(posedge clk) disable iff (!rst_n) cmd.out_err |=> out_status)
    else $error("missing error status");

endmodule

### src/emss_ctrl.sv
// Controller: sequences ops and the stats sweep.
module emss_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           op,
  input  logic                 idx_err,
  input  logic                 out_busy,
  input  emss_pkg::stat_t      st,
  output emss_pkg::ctrl_t      cmd
);

  emss_pkg::state_t state_r, state_nxt;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= emss_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Decode next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      emss_pkg::ST_IDLE: begin
        in_stall = out_busy;
        if (in_valid && !out_busy) begin
          if (op == emss_pkg::OP_STATS) begin
            state_nxt = emss_pkg::ST_CLR;
          end else if (idx_err) begin
            cmd.out_load = 1'b1;
            cmd.out_err  = 1'b1;
          end else if (op == emss_pkg::OP_READ) begin
            cmd.rd_issue = 1'b1;
            state_nxt    = emss_pkg::ST_READ;
          end else begin
            cmd.do_write = (op == emss_pkg::OP_WRITE);
            cmd.do_deact = (op == emss_pkg::OP_DEACT);
            cmd.out_load = 1'b1;
          end
        end
      end
      emss_pkg::ST_READ: begin
        cmd.out_load = 1'b1;
        state_nxt    = emss_pkg::ST_IDLE;
      end
      emss_pkg::ST_CLR: begin
        cmd.clr_acc = 1'b1;
        state_nxt   = emss_pkg::ST_ACC;
      end
      emss_pkg::ST_ACC: begin
        cmd.acc_issue = 1'b1;
        if (st.last_member) state_nxt = emss_pkg::ST_DRAIN;
      end
      // Wait until the fetch and square stages have emptied into the sums
      emss_pkg::ST_DRAIN: begin
        if (!st.pipe_busy) begin
          cmd.div_start = 1'b1;
          state_nxt     = emss_pkg::ST_DIV;
        end
      end
      emss_pkg::ST_DIV: begin
        if (st.div_done) state_nxt = emss_pkg::ST_SQ;
      end
      emss_pkg::ST_SQ: begin
        cmd.sq_load = 1'b1;
        state_nxt   = emss_pkg::ST_SQRT;
      end
      emss_pkg::ST_SQRT: begin
        if (st.sqrt_done) state_nxt = emss_pkg::ST_STORE;
        else cmd.sqrt_start = 1'b0;
      end
      emss_pkg::ST_STORE: begin
        cmd.store_stats = 1'b1;
        state_nxt = st.last_obs ? emss_pkg::ST_OUT : emss_pkg::ST_CLR;
      end
      emss_pkg::ST_OUT: begin
        if (!out_busy) begin
          cmd.out_load  = 1'b1;
          cmd.out_stats = 1'b1;
          state_nxt     = emss_pkg::ST_IDLE;
        end
      end
      default: state_nxt = emss_pkg::ST_IDLE;
    endcase
    if (state_r == emss_pkg::ST_SQ) cmd.sqrt_start = 1'b1;
  end

endmodule

### src/emss_dp.sv
// Datapath: sample memory, accumulators, divider, square root, stats stores, output register.
module emss_dp #(
  parameter int ENS_MAX = emss_pkg::ENS_MAX_DEF,
  parameter int OBS_MAX = emss_pkg::OBS_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [emss_pkg::CFG_W-1:0]    cfg_data,
  input  logic [1:0]                    op,
  input  logic [emss_pkg::IDX_W-1:0]    member_index,
  input  logic [emss_pkg::IDX_W-1:0]    obs_addr,
  input  logic signed [31:0]            sample_value,
  input  emss_pkg::ctrl_t               cmd,
  output emss_pkg::stat_t               st,
  output logic                          idx_err,
  output logic                          out_busy,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic signed [31:0]            mean_value,
  output logic [emss_pkg::STD_W-1:0]    std_value,
  output logic                          obs_active,
  output logic                          status
);

  localparam int EW  = (ENS_MAX > 1) ? $clog2(ENS_MAX) : 1;
  localparam int OW  = (OBS_MAX > 1) ? $clog2(OBS_MAX) : 1;
  localparam int NW  = $clog2(ENS_MAX + 1) + 1;
  localparam int DEP = ENS_MAX * OBS_MAX;
  localparam int AW  = (DEP > 1) ? $clog2(DEP) : 1;

  // Configuration registers
  logic [emss_pkg::CFG_W-1:0] ens_cfg_r, obs_cfg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ens_cfg_r <= emss_pkg::CFG_W'(64);
      obs_cfg_r <= emss_pkg::CFG_W'(64);
    end else if (cfg_we) begin
      if (cfg_index == emss_pkg::CFG_ENS) ens_cfg_r <= cfg_data;
      else                                 obs_cfg_r <= cfg_data;
    end
  end

  // Clamp the counts
  logic [10:0] n_eff, nobs_eff;
  always_comb begin
    n_eff = (ens_cfg_r == '0) ? 11'd1 : 11'(ens_cfg_r);
    if (n_eff > 11'(ENS_MAX)) n_eff = 11'(ENS_MAX);
    nobs_eff = (obs_cfg_r == '0) ? 11'd1 : 11'(obs_cfg_r);
    if (nobs_eff > 11'(OBS_MAX)) nobs_eff = 11'(OBS_MAX);
  end

  assign idx_err = (11'(obs_addr) >= nobs_eff) ||
                   ((op == emss_pkg::OP_WRITE) && (11'(member_index) >= n_eff));

  // Sample memory
  logic [31:0] smem [DEP];
  logic [31:0] srd_r;
  logic [EW-1:0] mem_r;
  logic [OW-1:0] obs_r;
  logic [AW-1:0] wr_addr, rd_addr;
  assign wr_addr = AW'(32'(obs_addr) * ENS_MAX + 32'(member_index));
  assign rd_addr = AW'(32'(obs_r) * ENS_MAX + 32'(mem_r));
  always_ff @(posedge clk) begin
    if (cmd.do_write) smem[wr_addr] <= sample_value;
    srd_r <= smem[rd_addr];
  end

  // Flags and stats stores
  logic [OBS_MAX-1:0] act_r;
  logic [31:0] mean_mem [OBS_MAX];
  logic [30:0] std_mem [OBS_MAX];
  logic [31:0] mrd_r;
  logic [30:0] srd2_r;
  logic [31:0] mean_r;
  logic [31:0] sd_r;
  always_ff @(posedge clk) begin
    if (!rst_n) act_r <= '0;
    else if (cmd.do_write) act_r[OW'(obs_addr)] <= 1'b1;
    else if (cmd.do_deact) act_r[OW'(obs_addr)] <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.store_stats) begin
      mean_mem[obs_r] <= mean_r;
      std_mem[obs_r]  <= (sd_r > 32'h7FFFFFFF) ? 31'h7FFFFFFF : sd_r[30:0];
    end
    if (cmd.rd_issue) begin
      mrd_r  <= mean_mem[OW'(obs_addr)];
      srd2_r <= std_mem[OW'(obs_addr)];
    end
  end
  logic act_rd_r;
  always_ff @(posedge clk) if (cmd.rd_issue) act_rd_r <= act_r[OW'(obs_addr)];

  // Sweep counters and read-valid pipe
  logic rdv_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_r <= '0; obs_r <= '0; rdv_r <= 1'b0;
    end else begin
      rdv_r <= cmd.acc_issue;
      if (cmd.acc_issue) mem_r <= st.last_member ? '0 : mem_r + EW'(1);
      if (cmd.store_stats) obs_r <= st.last_obs ? '0 : obs_r + OW'(1);
    end
  end
  assign st.last_member = (11'(mem_r) == n_eff - 11'd1);
  assign st.last_obs    = (11'(obs_r) == nobs_eff - 11'd1);

  // Square the fetched sample, then accumulate
  logic [63:0] sq_r;
  logic sqv_r;
  logic signed [31:0] s_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) sqv_r <= 1'b0;
    else sqv_r <= rdv_r;
    sq_r  <= 64'($signed(srd_r) * $signed(srd_r));
    s_d_r <= srd_r;
  end
  assign st.pipe_busy = rdv_r | sqv_r;
  logic signed [47:0] m1_r;
  logic [79:0] m2_r;
  always_ff @(posedge clk) begin
    if (cmd.clr_acc) begin
      m1_r <= '0; m2_r <= '0;
    end else if (sqv_r) begin
      m1_r <= m1_r + 48'(s_d_r);
      m2_r <= m2_r + 80'(sq_r);
    end
  end

  // Restoring dividers for |M1|/n and M2/n, one bit a cycle
  logic [79:0] q2_r; logic [NW-1:0] r2_r;
  logic [47:0] q1_r; logic [NW-1:0] r1_r;
  logic m1neg_r;
  logic [6:0] dcnt_r;
  logic dbusy_r;
  logic [NW:0] t1, t2;
  always_comb begin
    t1 = {r1_r, q1_r[47]};
    t2 = {r2_r, q2_r[79]};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0; dcnt_r <= '0;
    end else if (cmd.div_start) begin
      dbusy_r <= 1'b1; dcnt_r <= 7'd0;
      m1neg_r <= m1_r[47];
      q1_r <= m1_r[47] ? 48'(-m1_r) : 48'(m1_r);
      q2_r <= m2_r; r1_r <= '0; r2_r <= '0;
    end else if (dbusy_r) begin
      dcnt_r <= dcnt_r + 7'd1;
      if (dcnt_r == 7'd79) dbusy_r <= 1'b0;
      if (t2 >= (NW+1)'(n_eff)) begin
        r2_r <= NW'(t2 - (NW+1)'(n_eff)); q2_r <= {q2_r[78:0], 1'b1};
      end else begin
        r2_r <= NW'(t2); q2_r <= {q2_r[78:0], 1'b0};
      end
      if (dcnt_r < 7'd48) begin
        if (t1 >= (NW+1)'(n_eff)) begin
          r1_r <= NW'(t1 - (NW+1)'(n_eff)); q1_r <= {q1_r[46:0], 1'b1};
        end else begin
          r1_r <= NW'(t1); q1_r <= {q1_r[46:0], 1'b0};
        end
      end
    end
  end
  assign st.div_done = dbusy_r && (dcnt_r == 7'd79) ? 1'b0 : (!dbusy_r && !cmd.div_start);

  // Mean, mean squared and variance
  logic [63:0] msq_r;
  logic [63:0] var_r;
  always_ff @(posedge clk) begin
    if (cmd.sq_load) begin
      mean_r <= m1neg_r ? 32'(-q1_r) : q1_r[31:0];
      msq_r  <= 64'(q1_r[31:0] * q1_r[31:0]);
    end
  end
  assign var_r = (q2_r[63:0] > msq_r) ? q2_r[63:0] - msq_r : '0;

  // Bit-pair square root, one result bit a cycle
  logic [63:0] rv_r, rres_r, rbit_r;
  logic sbusy_r, sphase_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbusy_r <= 1'b0; sphase_r <= 1'b0;
    end else if (cmd.sqrt_start) begin
      sphase_r <= 1'b1; sbusy_r <= 1'b0;
    end else if (sphase_r) begin
      sphase_r <= 1'b0; sbusy_r <= 1'b1;
      rv_r <= var_r; rres_r <= '0; rbit_r <= 64'h4000000000000000;
    end else if (sbusy_r) begin
      if (rbit_r == '0) begin
        sbusy_r <= 1'b0;
      end else begin
        if (rv_r >= rres_r + rbit_r) begin
          rv_r <= rv_r - (rres_r + rbit_r);
          rres_r <= (rres_r >> 1) + rbit_r;
        end else begin
          rres_r <= rres_r >> 1;
        end
        rbit_r <= rbit_r >> 2;
      end
    end
  end
  assign sd_r = (rres_r > 64'hFFFFFFFF) ? 32'hFFFFFFFF : rres_r[31:0];
  assign st.sqrt_done = sbusy_r && (rbit_r == '0);

  // Output register
  logic ov_r;
  logic [31:0] omean_r; logic [30:0] ostd_r; logic oact_r, ost_r;
  logic rd_pend_r;
  always_ff @(posedge clk) begin
    if (!rst_n) rd_pend_r <= 1'b0;
    else rd_pend_r <= cmd.rd_issue;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.out_load) ov_r <= 1'b1;
    else if (!out_stall) ov_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      omean_r <= '0; ostd_r <= '0; oact_r <= 1'b0; ost_r <= 1'b0;
      if (cmd.out_err) ost_r <= 1'b1;
      else if (rd_pend_r) begin
        omean_r <= mrd_r; ostd_r <= srd2_r; oact_r <= act_rd_r;
      end else if (!cmd.out_stats) oact_r <= (op == emss_pkg::OP_WRITE);
    end
  end
  assign out_busy   = ov_r && out_stall;
  assign out_valid  = ov_r;
  assign mean_value = omean_r;
  assign std_value  = ostd_r;
  assign obs_active = oact_r;
  assign status     = ost_r;

endmodule
